@@ rtl/lacc_pkg.sv @@
// Shared constants, types and the softplus correction table for the loss accumulator.
package lacc_pkg;

   // Softplus correction table: g(t) = ln(1 + e^-t) sampled over t in [0,16).
   localparam int SP_ENTRIES = 256;
   localparam int SP_IDX_W   = $clog2(SP_ENTRIES);
   // |d| below 16.0 in Q16 has 20 bits; the table position carries a 20-bit fraction.
   localparam int SP_POS_W   = 20 + SP_IDX_W;

   localparam logic [1:0] MODE_LOGISTIC = 2'd0;
   localparam logic [1:0] MODE_SQUARED  = 2'd1;
   localparam logic [1:0] MODE_HINGE    = 2'd2;

   typedef logic [63:0] u64_type;
   typedef logic signed [63:0] s64_type;
   typedef logic [15:0] sp_table_type [SP_ENTRIES];

   // Restoring shift-and-subtract quotient, used only while the table is built.
   function automatic u64_type udiv64(input u64_type num, input u64_type den);
      u64_type     quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Builds the table with the same Q31 series the loss definition uses, then
   // forces it non-increasing. Evaluated once at elaboration.
   function automatic sp_table_type build_sp_table();
      sp_table_type tbl;
      u64_type x;
      u64_type term;
      u64_type r;
      u64_type z;
      u64_type z2;
      u64_type p;
      u64_type acc;
      u64_type g;
      s64_type sum;
      for (int i = 0; i < SP_ENTRIES; i++) begin
         x = udiv64(u64_type'(i) << 31, u64_type'(SP_ENTRIES));
         // e^(-x) series in Q31, then raised to the 16th power by squaring.
         sum  = s64_type'(64'd1 << 31);
         term = 64'd1 << 31;
         for (int k = 1; k <= 24; k++) begin
            term = udiv64((term * x + (64'd1 << 30)) >> 31, u64_type'(k));
            if (k[0]) begin
               sum = sum - s64_type'(term);
            end else begin
               sum = sum + s64_type'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         r = u64_type'(sum);
         if (r > (64'd1 << 31)) begin
            r = 64'd1 << 31;
         end
         for (int k = 0; k < 4; k++) begin
            r = (r * r + (64'd1 << 30)) >> 31;
         end
         // ln(1+u) = 2*atanh(u/(2+u)), odd series in Q31.
         z   = udiv64(r << 31, (64'd1 << 32) + r);
         z2  = (z * z + (64'd1 << 30)) >> 31;
         p   = z;
         acc = 64'd0;
         for (int k = 0; k < 16; k++) begin
            acc = acc + udiv64(p, u64_type'(2 * k + 1));
            p   = (p * z2 + (64'd1 << 30)) >> 31;
         end
         g = ((64'd2 * acc + (64'd1 << 14)) >> 15) & 64'hFFFF_FFFF;
         if (i > 0) begin
            if (g > u64_type'(tbl[i-1])) begin
               g = u64_type'(tbl[i-1]);
            end
         end
         tbl[i] = g[15:0];
      end
      return tbl;
   endfunction

   localparam sp_table_type SP_TABLE = build_sp_table();

endpackage

@@ rtl/loss_accumulator_top.sv @@
// Loss accumulator top level: sequencer around one shared 33x33 signed multiplier.
//
// Each item (prediction d, target y in signed Q15.16) produces one result with
// its point loss (unsigned Q24.16, saturating), the running sum (Q32.16,
// saturating) and tlast copied from the item; on a last item the sum is
// reported and then cleared. loss_mode selects logistic (softplus(d) - y*d,
// negative values give 0), squared error ((y-d)^2) or squared hinge
// ((1-d*y)^2 when positive); mode 3 gives 0. After its item is accepted, a
// result takes two passes through the shared multiplier (the product or
// square, then the softplus interpolation or the hinge square), a rounding
// step and the accumulate step. req_tready is high only while the sequencer
// is idle, so the next item can be accepted in the cycle the result appears,
// but not before the previous result is registered. A result waits in the
// output register while the next item is accepted; the accumulate step holds
// until that register is free. Write loss_mode only while no item is in flight.
module loss_accumulator_top (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: [31:0] prediction, [63:32] target
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,
   input  logic         req_tlast,
   // rsp_tdata: [39:0] point_loss, [87:40] total_loss
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_LOSS = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic [39:0] POINT_MAX = {40{1'b1}};
   localparam logic [47:0] SUM_MAX   = {48{1'b1}};

   localparam int SP_POS_W_L = lacc_pkg::SP_POS_W;

   // Adds one half LSB of Q16 to a Q32 value and saturates the Q16 result.
   function automatic logic [39:0] round_sat(input logic signed [65:0] v);
      logic [65:0] s;
      s = 66'(v) + 66'd32768;
      if (|s[65:56]) begin
         return POINT_MAX;
      end
      return s[55:16];
   endfunction

   logic [2:0]         state_ff, state_in;
   logic [1:0]         mode_ff;
   logic signed [31:0] d_ff, y_ff;
   logic               last_ff;
   logic signed [65:0] prod_ff;
   logic signed [63:0] yd_ff;
   logic [15:0]        cur_ff, diff_ff;
   logic [19:0]        frac_ff;
   logic               in_range_ff;
   logic               hinge_pos_ff;
   logic [39:0]        pl_ff, pl_in;
   logic [47:0]        sum_ff;
   logic               rsp_valid_ff;
   logic [39:0]        rsp_point_ff;
   logic [47:0]        rsp_total_ff;
   logic               rsp_last_ff;

   logic signed [32:0]  mul_a, mul_b;
   logic signed [65:0]  mul_p;
   logic signed [32:0]  sq_diff;
   logic signed [32:0]  sq_mag;
   logic [31:0]         abs_d;
   logic [SP_POS_W_L-1:0] sp_pos;
   logic [lacc_pkg::SP_IDX_W-1:0] sp_idx, sp_idx_nxt;
   logic [15:0]         sp_cur, sp_next;
   logic signed [65:0]  hinge_z;
   logic [44:0]         hinge_zc;
   logic [45:0]         hinge_rnd;
   logic [28:0]         z16;
   logic [36:0]         interp_rnd;
   logic [15:0]         sp_g;
   logic [32:0]         sp_val;
   logic signed [65:0]  logit_l32;
   logic [48:0]         sum_add;
   logic [47:0]         sum_new;
   logic                accept_in, fire_out;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept_in  = req_tvalid && req_tready;
   assign fire_out   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Configuration port.
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = 32'd0;
      if (!csr_paddr[2]) begin
         csr_prdata = {30'd0, mode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= lacc_pkg::MODE_LOGISTIC;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]) begin
         mode_ff <= csr_pwdata[1:0];
      end
   end

   // Operands of the first pass.
   assign sq_diff = {y_ff[31], y_ff} - {d_ff[31], d_ff};
   assign sq_mag  = sq_diff[32] ? -sq_diff : sq_diff;
   assign abs_d   = d_ff[31] ? (~d_ff + 32'sd1) : d_ff;

   // Table position |d| * N with a 20-bit fraction; only used when |d| < 16.
   assign sp_pos     = {{lacc_pkg::SP_IDX_W{1'b0}}, abs_d[19:0]}
                       * SP_POS_W_L'(lacc_pkg::SP_ENTRIES);
   assign sp_idx     = sp_pos[SP_POS_W_L-1:20];
   assign sp_idx_nxt = sp_idx + 1'b1;
   always_comb begin
      sp_cur  = lacc_pkg::SP_TABLE[sp_idx];
      sp_next = 16'd0;
      if (sp_idx != lacc_pkg::SP_IDX_W'(lacc_pkg::SP_ENTRIES - 1)) begin
         sp_next = lacc_pkg::SP_TABLE[sp_idx_nxt];
      end
      if (sp_next > sp_cur) begin
         sp_next = sp_cur;
      end
   end

   // Hinge margin 1 - d*y in Q32, clamped and rounded to Q16.
   assign hinge_z   = 66'sh1_0000_0000 - prod_ff;
   assign hinge_zc  = (hinge_z > 66'sh1000_0000_0000) ? 45'h1000_0000_0000 : hinge_z[44:0];
   assign hinge_rnd = {1'b0, hinge_zc} + 46'd32768;
   assign z16       = hinge_rnd[44:16];

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = {d_ff[31], d_ff};
      mul_b = {y_ff[31], y_ff};
      if (state_ff == ST_MUL1) begin
         if (mode_ff == lacc_pkg::MODE_SQUARED) begin
            mul_a = sq_mag;
            mul_b = sq_mag;
         end
      end else begin
         if (mode_ff == lacc_pkg::MODE_HINGE) begin
            mul_a = {4'd0, z16};
            mul_b = {4'd0, z16};
         end else begin
            mul_a = {17'd0, diff_ff};
            mul_b = {13'd0, frac_ff};
         end
      end
   end
   assign mul_p = mul_a * mul_b;

   // Logistic loss from the interpolation product and the saved y*d.
   assign interp_rnd = prod_ff[36:0] + 37'd524288;
   assign sp_g       = in_range_ff ? (cur_ff - interp_rnd[35:20]) : 16'd0;
   assign sp_val     = (d_ff[31] ? 33'd0 : {1'b0, d_ff}) + {17'd0, sp_g};
   assign logit_l32  = $signed({17'd0, sp_val, 16'd0}) - {{2{yd_ff[63]}}, yd_ff};

   always_comb begin
      pl_in = 40'd0;
      case (mode_ff)
         lacc_pkg::MODE_LOGISTIC: begin
            if (logit_l32 > 66'sd0) begin
               pl_in = round_sat(logit_l32);
            end
         end
         lacc_pkg::MODE_SQUARED: pl_in = round_sat(prod_ff);
         lacc_pkg::MODE_HINGE: begin
            if (hinge_pos_ff) begin
               pl_in = round_sat(prod_ff);
            end
         end
         default: pl_in = 40'd0;
      endcase
   end

   assign sum_add = {1'b0, sum_ff} + {9'd0, pl_ff};
   assign sum_new = sum_add[48] ? SUM_MAX : sum_add[47:0];

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept_in) state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_LOSS;
         ST_LOSS: state_in = ST_DONE;
         ST_DONE: if (fire_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= 48'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fire_out) begin
            rsp_valid_ff <= 1'b1;
            sum_ff       <= last_ff ? 48'd0 : sum_new;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept_in) begin
         d_ff    <= req_tdata[31:0];
         y_ff    <= req_tdata[63:32];
         last_ff <= req_tlast;
      end
      if (state_ff == ST_MUL1) begin
         prod_ff     <= mul_p;
         cur_ff      <= sp_cur;
         diff_ff     <= sp_cur - sp_next;
         frac_ff     <= sp_pos[19:0];
         in_range_ff <= (abs_d[31:20] == 12'd0);
      end
      if (state_ff == ST_MUL2) begin
         yd_ff        <= prod_ff[63:0];
         hinge_pos_ff <= (hinge_z > 66'sd0);
         if (mode_ff != lacc_pkg::MODE_SQUARED) begin
            prod_ff <= mul_p;
         end
      end
      if (state_ff == ST_LOSS) begin
         pl_ff <= pl_in;
      end
      if (fire_out) begin
         rsp_point_ff <= pl_ff;
         rsp_total_ff <= sum_new;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_point_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ rtl/lacc_checker.sv @@
// Port-level checks for the loss accumulator, bound to the top level.
module lacc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // The sequencer takes one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item is in progress");

   // The running sum always includes the point loss it is reported with.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[87:40] >= {8'd0, rsp_tdata[39:0]})
      else $error("total loss below point loss");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind loss_accumulator_top lacc_checker u_lacc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/loss_accumulator_checker.sv @@
`timescale 1ns / 100ps
// Checker for the loss accumulator: tracks loss_mode, predicts every result item and compares.
module loss_accumulator_checker #(
   parameter logic [2:0] MODE_ADDR = 3'd0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [63:0]  req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [87:0]  rsp_tdata,
   input  logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           outstanding,
   output int           mismatches
);

   localparam int          CORR_POINTS = 256;
   localparam logic [63:0] Q31_ONE     = 64'd1 << 31;
   localparam logic [39:0] POINT_SAT   = '1;
   localparam logic [47:0] SUM_SAT     = '1;

   typedef struct packed {
      logic [39:0] point_loss;
      logic [47:0] total_loss;
      logic        total_valid;
   } loss_result_type;

   loss_result_type losses_due[$];
   logic [63:0]  ln_corr [CORR_POINTS];
   logic [63:0]  running_sum;
   logic [1:0]   mode_shadow;
   int           error_total = 0;

   function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
      return (a * b + (64'd1 << 30)) >> 31;
   endfunction

   // Rounds a Q32 value half up to Q16, without wrapping at the top of the range.
   function automatic logic [63:0] q16_round(input logic [63:0] v);
      if (v > 64'hFFFF_FFFF_FFFF_7FFF) begin
         return v >> 16;
      end
      return (v + 64'd32768) >> 16;
   endfunction

   // Correction table g(t) = ln(1 + e^-t) over t in [0,16), built with Q31 series.
   initial begin
      logic [63:0] x, term, r, z, z2, p, acc, g;
      longint      series;
      for (int i = 0; i < CORR_POINTS; i++) begin
         x      = (64'(i) << 31) / CORR_POINTS;
         series = longint'(Q31_ONE);
         term   = Q31_ONE;
         for (int k = 1; k <= 24; k++) begin
            term = q31_mul(term, x) / 64'(k);
            if (k % 2 == 1) begin
               series = series - longint'(term);
            end else begin
               series = series + longint'(term);
            end
         end
         if (series < 0) begin
            series = 0;
         end
         r = series;
         if (r > Q31_ONE) begin
            r = Q31_ONE;
         end
         repeat (4) r = q31_mul(r, r);
         z   = (r << 31) / ((64'd1 << 32) + r);
         z2  = q31_mul(z, z);
         p   = z;
         acc = 64'd0;
         for (int k = 0; k < 16; k++) begin
            acc = acc + p / 64'(2 * k + 1);
            p   = q31_mul(p, z2);
         end
         g = ((64'd2 * acc + (64'd1 << 14)) >> 15) & 64'hFFFF_FFFF;
         if (i > 0 && g > ln_corr[i-1]) begin
            g = ln_corr[i-1];
         end
         ln_corr[i] = g;
      end
   end

   function automatic logic [63:0] softplus_q16(input longint d);
      logic [63:0] mag, base, pos, idx, frac, cur, nxt, g;
      mag  = (d < 0) ? -d : d;
      base = (d > 0) ? d : 0;
      g    = 64'd0;
      if (mag < (64'd16 << 16)) begin
         pos  = mag * CORR_POINTS;
         idx  = pos >> 20;
         frac = pos & 64'hF_FFFF;
         if (idx >= CORR_POINTS) begin
            idx = CORR_POINTS - 1;
         end
         cur = ln_corr[idx];
         // Past the last table point the correction is taken as zero.
         nxt = 64'd0;
         if (idx + 1 < CORR_POINTS) begin
            nxt = ln_corr[idx+1];
         end
         if (nxt > cur) begin
            nxt = cur;
         end
         g = cur - (((cur - nxt) * frac + (64'd1 << 19)) >> 20);
      end
      return base + g;
   endfunction

   // Works out the point loss, folds it into the running sum and returns the result item.
   function automatic loss_result_type accumulate_loss(input logic [31:0] pred_bits,
                                                       input logic [31:0] targ_bits,
                                                       input logic        last);
      longint          d, y, l32, zs;
      logic [63:0]     pl, mag, zu, z16;
      loss_result_type res;
      d  = longint'($signed(pred_bits));
      y  = longint'($signed(targ_bits));
      pl = 64'd0;
      case (mode_shadow)
         lacc_pkg::MODE_LOGISTIC: begin
            l32 = softplus_q16(d) << 16;
            l32 = l32 - y * d;
            if (l32 > 0) begin
               pl = q16_round(l32);
            end
         end
         lacc_pkg::MODE_SQUARED: begin
            zs  = y - d;
            mag = (zs < 0) ? -zs : zs;
            pl  = q16_round(mag * mag);
         end
         lacc_pkg::MODE_HINGE: begin
            zs = longint'(64'd1 << 32) - d * y;
            if (zs > 0) begin
               zu = zs;
               if (zu > (64'd1 << 44)) begin
                  zu = 64'd1 << 44;
               end
               z16 = q16_round(zu);
               pl  = q16_round(z16 * z16);
            end
         end
         default: pl = 64'd0;
      endcase
      if (pl > POINT_SAT) begin
         pl = POINT_SAT;
      end
      running_sum = running_sum + pl;
      if (running_sum > SUM_SAT) begin
         running_sum = SUM_SAT;
      end
      res.point_loss  = pl[39:0];
      res.total_loss  = running_sum[47:0];
      res.total_valid = last;
      if (last) begin
         running_sum = 64'd0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      loss_result_type got, want;
      if (reset) begin
         losses_due.delete();
         running_sum = 64'd0;
         mode_shadow = lacc_pkg::MODE_LOGISTIC;
      end else begin
         // Registers sit at word addresses; the low byte-offset bits do not select.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == MODE_ADDR[2]) begin
            mode_shadow = csr_pwdata[1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got.point_loss  = rsp_tdata[39:0];
            got.total_loss  = rsp_tdata[87:40];
            got.total_valid = rsp_tlast;
            if (losses_due.size() == 0) begin
               if (error_total < 10) begin
                  $display("%0t: result item with nothing expected: point %h total %h last %b",
                           $realtime, got.point_loss, got.total_loss, got.total_valid);
               end
               error_total++;
            end else begin
               want = losses_due.pop_front();
               if (got != want) begin
                  if (error_total < 10) begin
                     $display("%0t: mismatch exp/got: point %h/%h total %h/%h last %b/%b",
                              $realtime, want.point_loss, got.point_loss, want.total_loss,
                              got.total_loss, want.total_valid, got.total_valid);
                  end
                  error_total++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            losses_due.push_back(accumulate_loss(req_tdata[31:0], req_tdata[63:32], req_tlast));
         end
      end
      outstanding <= losses_due.size();
      mismatches  <= error_total;
   end

endmodule

@@ tb/tb_loss_accumulator_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the loss accumulator: stimulus, handshake idling, watchdog and verdict.
module tb_loss_accumulator_top;

   localparam logic [1:0]  MODE_UNUSED   = 2'd3;
   localparam logic [2:0]  CSR_LOSS_MODE = 3'd0;
   localparam logic [2:0]  CSR_UNMAPPED  = 3'd4;
   localparam int          STALL_LIMIT   = 1000;
   localparam int          TAIL_CYCLES   = 12;
   localparam logic [31:0] Q16_ONE       = 32'h0001_0000;
   localparam logic [31:0] Q16_MINUS_ONE = 32'hFFFF_0000;
   localparam logic [31:0] Q16_MAX       = 32'h7FFF_FFFF;
   localparam logic [31:0] Q16_MIN       = 32'h8000_0000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;     // [31:0] prediction, [63:32] target
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [87:0] rsp_tdata;            // [39:0] point_loss, [87:40] total_loss
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int outstanding;
   int mismatches;
   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   int items_sent   = 0;
   int stall_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   loss_accumulator_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   loss_accumulator_checker #(.MODE_ADDR(CSR_LOSS_MODE)) loss_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Any handshake on either channel or the register port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_item(input logic [31:0] pred, input logic [31:0] targ, input logic last);
      if (items_sent < 325) begin
         tx_idle_pct = 18;
         rx_idle_pct <= 76;
      end else if (items_sent < 650) begin
         tx_idle_pct = 76;
         rx_idle_pct <= 18;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct <= 0;
      end
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {targ, pred};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Holds the sender off until every expected result item has been taken.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [31:0] random_q16();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom_range(40 << 16) - (20 << 16);
         4, 5:       return $urandom_range(32'h0200_0000) - 32'h0100_0000;
         6:          return $urandom();
         7: begin
            case ($urandom_range(5))
               0:       return Q16_MIN;
               1:       return Q16_MAX;
               2:       return 32'd0;
               3:       return 32'd1;
               4:       return 32'hFFFF_FFFF;
               default: return Q16_ONE;
            endcase
         end
         // Around the edge of the softplus table range, on either side of zero.
         default: return ($urandom_range(1) ? 32'h0010_0000 : 32'hFFF0_0000)
                         + $urandom_range(512) - 256;
      endcase
   endfunction

   function automatic logic [31:0] random_target();
      if ($urandom_range(1)) begin
         case ($urandom_range(2))
            0:       return 32'd0;
            1:       return Q16_ONE;
            default: return Q16_MINUS_ONE;
         endcase
      end
      return random_q16();
   endfunction

   task automatic run_segment(input logic [1:0] mode, input int count, input bit saturate);
      write_csr(CSR_LOSS_MODE, ($urandom() & ~32'h3) | mode);
      for (int n = 0; n < count; n++) begin
         // Saturating runs keep every point loss at its ceiling so the sum clamps too.
         if (saturate) begin
            send_item(Q16_MIN | $urandom_range(32'h0FFF_FFFF),
                      32'h7000_0000 | $urandom_range(32'h0FFF_FFFF), n == count - 1);
         end else begin
            send_item(random_q16(), random_target(), $urandom_range(9) == 0);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // A write to an unmapped address must leave the logistic mode in place.
      write_csr(CSR_UNMAPPED, 32'h0000_0001);
      send_item(32'd0, 32'd0, 1'b0);
      send_item(Q16_MAX, Q16_MIN, 1'b0);
      send_item(Q16_MIN, Q16_MIN, 1'b0);
      send_item(32'h000A_0000, Q16_ONE, 1'b0);
      send_item(32'h0010_0000, 32'd0, 1'b0);
      send_item(32'h000F_FFFF, 32'd0, 1'b0);
      send_item(32'hFFF0_0001, 32'd0, 1'b0);
      send_item(32'hFFFC_8000, Q16_ONE, 1'b1);

      // Upper bits of the written value are dropped, leaving squared error.
      write_csr(CSR_LOSS_MODE, 32'hFFFF_FFFD);
      send_item(Q16_MIN, Q16_MAX, 1'b0);
      send_item(Q16_MAX, Q16_MIN, 1'b0);
      send_item(32'h0001_8000, 32'hFFFD_C000, 1'b1);
      send_item(32'd1, 32'd0, 1'b0);

      write_csr(CSR_LOSS_MODE, {30'd0, lacc_pkg::MODE_HINGE});
      send_item(Q16_ONE, Q16_ONE, 1'b0);
      send_item(32'h0000_8000, Q16_ONE, 1'b0);
      send_item(Q16_MIN, Q16_MAX, 1'b0);
      send_item(Q16_MIN, Q16_MIN, 1'b0);
      send_item(32'h0003_0000, Q16_MINUS_ONE, 1'b1);

      write_csr(CSR_LOSS_MODE, {30'd0, MODE_UNUSED});
      send_item(32'h0002_0000, 32'h0005_0000, 1'b0);
      send_item(Q16_MIN, Q16_MAX, 1'b1);

      run_segment(lacc_pkg::MODE_LOGISTIC, 150, 1'b0);
      run_segment(lacc_pkg::MODE_SQUARED, 150, 1'b0);
      run_segment(lacc_pkg::MODE_HINGE, 150, 1'b0);
      run_segment(MODE_UNUSED, 20, 1'b0);
      run_segment(lacc_pkg::MODE_SQUARED, 270, 1'b1);
      run_segment(lacc_pkg::MODE_LOGISTIC, 70, 1'b0);
      run_segment(lacc_pkg::MODE_HINGE, 70, 1'b0);
      run_segment(lacc_pkg::MODE_SQUARED, 70, 1'b0);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/lacc_pkg.sv
rtl/loss_accumulator_top.sv
rtl/lacc_checker.sv
tb/loss_accumulator_checker.sv
tb/tb_loss_accumulator_top.sv
